FILE: rtl/lsbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsbc_pkg;

	localparam int MUL_W  = 17;
	localparam int PROD_W = 2 * MUL_W;
	localparam int COORD_W = 17;
	localparam int RANGE_W = 16;
	localparam int ANGLE_W = 16;
	localparam int LIMIT_W = 32;
	localparam int LABEL_OUT_W = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_DIST_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 2'd2;

	localparam logic [LIMIT_W-1:0] DIST_LIMIT_RST  = 32'd2621;
	localparam logic [ANGLE_W-1:0] START_ANGLE_RST = 16'd0;
	localparam logic [ANGLE_W-1:0] ANGLE_STEP_RST  = 16'd182;

	// Quarter-wave sine polynomial coefficients, Q14 arguments, Q16 result.
	localparam logic [MUL_W-1:0] COEF_A = 17'd102944;
	localparam logic [15:0]      COEF_B = 16'd42047;
	localparam logic [MUL_W-1:0] COEF_C = 17'd4639;

	localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
	localparam logic [14:0]        QUARTER_ONE  = 15'd16384;

	typedef struct packed {
		logic [LIMIT_W-1:0] dist_limit;
		logic [ANGLE_W-1:0] start_angle;
		logic [ANGLE_W-1:0] angle_step;
	} cfg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [LABEL_OUT_W-1:0]    label;
		logic                      opens;
		logic                      done;
		logic                      merge;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/lsbc_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module lsbc_mul (
	input  wire                              clk,
	input  wire  [lsbc_pkg::MUL_W-1:0]       a,
	input  wire  [lsbc_pkg::MUL_W-1:0]       b,
	output logic [lsbc_pkg::PROD_W-1:0]      prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

`default_nettype wire

FILE: rtl/lsbc_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module lsbc_seq #(
	parameter int SINE_TABLE_BITS = 10,
	parameter int LABEL_BITS      = 8
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire  lsbc_pkg::cfg_t              cfg,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire  [lsbc_pkg::RANGE_W-1:0]      in_range,
	input  wire                               in_last,
	output logic                              res_valid,
	input  wire                               res_ready,
	output lsbc_pkg::res_t                    res
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_QSQ  = 4'd1;
	localparam logic [3:0] ST_ZC   = 4'd2;
	localparam logic [3:0] ST_ZI   = 4'd3;
	localparam logic [3:0] ST_QS   = 4'd4;
	localparam logic [3:0] ST_RM   = 4'd5;
	localparam logic [3:0] ST_CRD  = 4'd6;
	localparam logic [3:0] ST_DX   = 4'd7;
	localparam logic [3:0] ST_DY   = 4'd8;
	localparam logic [3:0] ST_DS   = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;

	localparam int LOW_BITS = lsbc_pkg::ANGLE_W - SINE_TABLE_BITS;
	localparam logic [lsbc_pkg::ANGLE_W-1:0] PHASE_MASK =
		lsbc_pkg::ANGLE_W'({lsbc_pkg::ANGLE_W{1'b1}} << LOW_BITS);
	localparam logic [LABEL_BITS-1:0] LABEL_TOP = {LABEL_BITS{1'b1}};

	localparam int MW = lsbc_pkg::MUL_W;
	localparam int PW = lsbc_pkg::PROD_W;
	localparam int CW = lsbc_pkg::COORD_W;

	logic [3:0]                       state_q;
	logic [lsbc_pkg::ANGLE_W-1:0]     bearing_q;
	logic [lsbc_pkg::RANGE_W-1:0]     range_q;
	logic                             last_q;
	logic                             start_q;
	logic                             axis_q;
	logic                             dref_q;
	logic [14:0]                      z2_q;
	logic [PW-1:0]                    acc_q;
	logic signed [CW-1:0]             x_q;
	logic signed [CW-1:0]             y_q;
	logic signed [CW-1:0]             prev_x_q;
	logic signed [CW-1:0]             prev_y_q;
	logic signed [CW-1:0]             first_x_q;
	logic signed [CW-1:0]             first_y_q;
	logic [LABEL_BITS-1:0]            label_q;
	logic                             opens_q;
	logic                             merge_q;
	logic                             first_sample_q;

	logic [PW-1:0]                    prod_q;
	logic [MW-1:0]                    mul_a;
	logic [MW-1:0]                    mul_b;

	logic [lsbc_pkg::ANGLE_W-1:0]     angle;
	logic [14:0]                      q_mag;
	logic                             q_neg;
	logic [15:0]                      inner;
	logic [MW-1:0]                    s_val;
	logic [MW-1:0]                    mag;
	logic [PW:0]                      rnd;
	logic [CW-1:0]                    v_mag;
	logic signed [CW-1:0]             coord;
	logic signed [CW-1:0]             ref_x;
	logic signed [CW-1:0]             ref_y;
	logic [CW:0]                      dx;
	logic [CW:0]                      dy;
	logic [CW:0]                      adx;
	logic [CW:0]                      ady;
	logic [PW:0]                      dsum;
	logic                             below;
	logic [LABEL_BITS-1:0]            label_inc;
	logic [LABEL_BITS-1:0]            label_nxt;

	lsbc_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	always_comb begin
		angle = (bearing_q & PHASE_MASK) + (axis_q ? '0 : lsbc_pkg::QUARTER_TURN);
		q_mag = angle[14] ? (lsbc_pkg::QUARTER_ONE - {1'b0, angle[13:0]})
			: {1'b0, angle[13:0]};
		q_neg = angle[15];
		inner = lsbc_pkg::COEF_B - prod_q[29:14];
		s_val = lsbc_pkg::COEF_A - {1'b0, prod_q[29:14]};
		mag   = prod_q[30:14];
		rnd   = {1'b0, prod_q} + (PW+1)'(32768);
		v_mag = rnd[32:16];
		coord = q_neg ? CW'(-v_mag) : v_mag;

		ref_x = dref_q ? first_x_q : prev_x_q;
		ref_y = dref_q ? first_y_q : prev_y_q;
		dx    = {ref_x[CW-1], ref_x} - {x_q[CW-1], x_q};
		dy    = {ref_y[CW-1], ref_y} - {y_q[CW-1], y_q};
		adx   = dx[CW] ? (CW+1)'(-dx) : dx;
		ady   = dy[CW] ? (CW+1)'(-dy) : dy;
		dsum  = {1'b0, acc_q} + {1'b0, prod_q};
		below = dsum < (PW+1)'(cfg.dist_limit);

		label_inc = (label_q == LABEL_TOP) ? label_q : label_q + 1'b1;
		label_nxt = below ? label_q : label_inc;
	end

	always_comb begin
		case (state_q)
			ST_QSQ: begin
				mul_a = MW'(q_mag);
				mul_b = MW'(q_mag);
			end
			ST_ZC: begin
				mul_a = MW'(prod_q[28:14]);
				mul_b = lsbc_pkg::COEF_C;
			end
			ST_ZI: begin
				mul_a = MW'(z2_q);
				mul_b = MW'(inner);
			end
			ST_QS: begin
				mul_a = MW'(q_mag);
				mul_b = s_val;
			end
			ST_RM: begin
				mul_a = MW'(range_q);
				mul_b = mag;
			end
			ST_DX: begin
				mul_a = adx[MW-1:0];
				mul_b = adx[MW-1:0];
			end
			ST_DY: begin
				mul_a = ady[MW-1:0];
				mul_b = ady[MW-1:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ZC) begin
			z2_q <= prod_q[28:14];
		end
		if (state_q == ST_DY) begin
			acc_q <= prod_q;
		end
		if (in_valid && in_ready) begin
			range_q <= in_range;
			last_q  <= in_last;
			start_q <= first_sample_q;
		end
		if (state_q == ST_CRD) begin
			if (axis_q) begin
				y_q <= coord;
			end else begin
				x_q <= coord;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			bearing_q      <= '0;
			axis_q         <= 1'b0;
			dref_q         <= 1'b0;
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			first_x_q      <= '0;
			first_y_q      <= '0;
			label_q        <= '0;
			opens_q        <= 1'b0;
			merge_q        <= 1'b0;
			first_sample_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						bearing_q <= first_sample_q ? cfg.start_angle
							: bearing_q + cfg.angle_step;
						axis_q    <= 1'b0;
						dref_q    <= 1'b0;
						opens_q   <= first_sample_q;
						merge_q   <= 1'b0;
						if (first_sample_q) begin
							label_q <= '0;
						end
						state_q <= ST_QSQ;
					end
				end
				ST_QSQ: state_q <= ST_ZC;
				ST_ZC:  state_q <= ST_ZI;
				ST_ZI:  state_q <= ST_QS;
				ST_QS:  state_q <= ST_RM;
				ST_RM:  state_q <= ST_CRD;
				ST_CRD: begin
					if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= ST_QSQ;
					end else if (start_q) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DX;
					end
				end
				ST_DX: state_q <= ST_DY;
				ST_DY: state_q <= ST_DS;
				ST_DS: begin
					if (!dref_q) begin
						label_q <= label_nxt;
						if (!below) begin
							opens_q <= 1'b1;
						end
						if (last_q && label_nxt != '0) begin
							dref_q  <= 1'b1;
							state_q <= ST_DX;
						end else begin
							state_q <= ST_OUT;
						end
					end else begin
						merge_q <= below;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (res_ready) begin
						prev_x_q       <= x_q;
						prev_y_q       <= y_q;
						if (start_q) begin
							first_x_q <= x_q;
							first_y_q <= y_q;
						end
						first_sample_q <= last_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_OUT);

	always_comb begin
		res.x     = x_q;
		res.y     = y_q;
		res.label = lsbc_pkg::LABEL_OUT_W'(label_q);
		res.opens = opens_q;
		res.done  = last_q;
		res.merge = merge_q;
	end

endmodule

`default_nettype wire

FILE: rtl/laser_scan_breakpoint_clustering_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Each range sample is turned into a Cartesian point from its bearing and a
// polynomial sine, then labelled by comparing its squared distance to the
// previous point against distance_sq_limit; the final sample of a scan also
// reports whether the last cluster joins cluster 0. Every multiplication of
// the sine polynomial, the coordinate scaling and the squared distances runs
// in turn through a single registered 17 by 17 bit multiplier, so a new sample
// is accepted only once the previous one has been worked through; the first
// sample of a scan skips the distance pass, and a final sample of a scan with
// several clusters adds a second one against the first point. A finished
// result sits in an output register, so the next sample is accepted while it
// waits to be taken.

module laser_scan_breakpoint_clustering_unit #(
	parameter int SINE_TABLE_BITS = 10,
	parameter int LABEL_BITS      = 8
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_we,
	input  wire  [lsbc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [lsbc_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire                                   s_axis_tvalid,
	output logic                                  s_axis_tready,
	// Bits from the lowest up: range_value.
	input  wire  [15:0]                           s_axis_tdata,
	input  wire                                   s_axis_tlast,
	output logic                                  m_axis_tvalid,
	input  wire                                   m_axis_tready,
	// Bits from the lowest up: point_x, point_y, cluster_label, zero padding.
	output logic [47:0]                           m_axis_tdata,
	// Bits from the lowest up: opens_cluster, wrap_merge.
	output logic [1:0]                            m_axis_tuser,
	output logic                                  m_axis_tlast
);

	lsbc_pkg::cfg_t cfg_q;
	lsbc_pkg::res_t res;
	lsbc_pkg::res_t out_q;
	logic           res_valid;
	logic           res_ready;
	logic           m_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dist_limit  <= lsbc_pkg::DIST_LIMIT_RST;
			cfg_q.start_angle <= lsbc_pkg::START_ANGLE_RST;
			cfg_q.angle_step  <= lsbc_pkg::ANGLE_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lsbc_pkg::CFG_DIST_LIMIT:  cfg_q.dist_limit  <= cfg_data;
				lsbc_pkg::CFG_START_ANGLE: cfg_q.start_angle <= cfg_data[15:0];
				lsbc_pkg::CFG_ANGLE_STEP:  cfg_q.angle_step  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	lsbc_seq #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.LABEL_BITS      (LABEL_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_range  (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'd0, out_q.label, out_q.y, out_q.x};
	assign m_axis_tuser  = {out_q.merge, out_q.opens};
	assign m_axis_tlast  = out_q.done;

endmodule

`default_nettype wire

FILE: tb/tb_laser_scan_breakpoint_clustering_unit.sv
`timescale 1ns / 1ps

module tb_laser_scan_breakpoint_clustering_unit;

	localparam int SINE_BITS = 10;
	localparam int LABEL_TOP = (1 << 8) - 1;
	localparam logic [15:0] BEARING_MASK = 16'(16'hFFFF << (16 - SINE_BITS));
	localparam logic [lsbc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_SAMPLES = 70;
	localparam int DIRECTED_ROWS = 16;

	typedef struct {
		logic [15:0]        rng;
		logic               last;
		logic               typed;
		logic signed [16:0] x;
		logic signed [16:0] y;
	} sample_row_t;

	// Typed rows all start a scan at bearing zero, so they read x = range, y = 0.
	sample_row_t directed_rows [DIRECTED_ROWS] = '{
		'{16'd0,     1'b1, 1'b1, 17'sd0,     17'sd0},
		'{16'd65535, 1'b0, 1'b1, 17'sd65535, 17'sd0},
		'{16'd65535, 1'b0, 1'b0, 17'sd0,     17'sd0},
		'{16'd0,     1'b0, 1'b0, 17'sd0,     17'sd0},
		'{16'd0,     1'b0, 1'b0, 17'sd0,     17'sd0},
		'{16'd0,     1'b1, 1'b0, 17'sd0,     17'sd0},
		'{16'd1000,  1'b0, 1'b1, 17'sd1000,  17'sd0},
		'{16'd3000,  1'b0, 1'b0, 17'sd0,     17'sd0},
		'{16'd1000,  1'b1, 1'b0, 17'sd0,     17'sd0},
		'{16'd1,     1'b0, 1'b1, 17'sd1,     17'sd0},
		'{16'd1,     1'b1, 1'b0, 17'sd0,     17'sd0},
		'{16'd32768, 1'b0, 1'b1, 17'sd32768, 17'sd0},
		'{16'h5555,  1'b0, 1'b0, 17'sd0,     17'sd0},
		'{16'hAAAA,  1'b0, 1'b0, 17'sd0,     17'sd0},
		'{16'd65535, 1'b1, 1'b0, 17'sd0,     17'sd0},
		'{16'hFFFF,  1'b1, 1'b1, 17'sd65535, 17'sd0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [lsbc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [lsbc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic m_axis_tlast;

	logic [lsbc_pkg::LIMIT_W-1:0] mirror_limit = lsbc_pkg::DIST_LIMIT_RST;
	logic [lsbc_pkg::ANGLE_W-1:0] mirror_start = lsbc_pkg::START_ANGLE_RST;
	logic [lsbc_pkg::ANGLE_W-1:0] mirror_step = lsbc_pkg::ANGLE_STEP_RST;

	int track_prev_x = 0;
	int track_prev_y = 0;
	int track_first_x = 0;
	int track_first_y = 0;
	logic [15:0] track_bearing = '0;
	logic [7:0] track_label = '0;
	logic track_new_scan = 1'b1;

	lsbc_pkg::res_t pending_points [$];
	int mismatch_count = 0;
	int points_checked = 0;
	int samples_sent = 0;
	int scans_seen = 0;
	int merges_seen = 0;
	int saturated_seen = 0;
	logic src_gaps_on = 1'b1;
	logic sink_gaps_on = 1'b1;
	int hold_ticket = 0;
	int hold_served = 0;
	int hold_cnt = 0;

	laser_scan_breakpoint_clustering_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #2 clk = ~clk;

	function automatic longint unsigned quarter_wave(input longint unsigned q);
		longint unsigned z2;
		longint unsigned inner;
		longint unsigned s;
		z2 = (q * q) >> 14;
		inner = longint'(lsbc_pkg::COEF_B) - ((z2 * longint'(lsbc_pkg::COEF_C)) >> 14);
		s = longint'(lsbc_pkg::COEF_A) - ((z2 * inner) >> 14);
		return (q * s) >> 14;
	endfunction

	function automatic int range_times_sine(input logic [15:0] rng, input logic [15:0] angle);
		longint unsigned mag;
		longint unsigned v;
		if (angle[14])
			mag = quarter_wave(longint'(16384) - longint'(angle[13:0]));
		else
			mag = quarter_wave(longint'(angle[13:0]));
		v = (longint'(rng) * mag + 32768) >> 16;
		if (angle[15])
			return -int'(v);
		return int'(v);
	endfunction

	function automatic longint unsigned span_sq(input int ax, input int ay, input int bx,
			input int by);
		longint dx;
		longint dy;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		return longint'(dx * dx) + longint'(dy * dy);
	endfunction

	function automatic lsbc_pkg::res_t predict_point(input logic [15:0] rng, input logic last);
		lsbc_pkg::res_t p;
		logic starting;
		logic [15:0] phase;
		int x;
		int y;
		logic opens;
		logic merge;
		starting = track_new_scan;
		opens = 1'b0;
		merge = 1'b0;
		if (starting)
			track_bearing = mirror_start;
		else
			track_bearing = track_bearing + mirror_step;
		phase = track_bearing & BEARING_MASK;
		x = range_times_sine(rng, phase + lsbc_pkg::QUARTER_TURN);
		y = range_times_sine(rng, phase);
		if (starting) begin
			track_label = '0;
			opens = 1'b1;
			track_first_x = x;
			track_first_y = y;
		end else if (span_sq(track_prev_x, track_prev_y, x, y) >= longint'(mirror_limit)) begin
			opens = 1'b1;
			if (track_label < LABEL_TOP)
				track_label = track_label + 8'd1;
		end
		if (last && !starting && track_label != 0)
			merge = span_sq(track_first_x, track_first_y, x, y) < longint'(mirror_limit);
		track_prev_x = x;
		track_prev_y = y;
		track_new_scan = last;
		p.x = 17'(x);
		p.y = 17'(y);
		p.label = track_label;
		p.opens = opens;
		p.done = last;
		p.merge = merge;
		return p;
	endfunction

	task automatic send_sample(input logic [15:0] rng, input logic last, input logic typed,
			input lsbc_pkg::res_t want);
		while (src_gaps_on && $urandom_range(0, 99) < 24) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= rng;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (typed) begin
			void'(predict_point(rng, last));
			pending_points.insert(pending_points.size(), want);
		end else begin
			pending_points.insert(pending_points.size(), predict_point(rng, last));
		end
		samples_sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
	endtask

	task automatic apply_setting(input logic [31:0] limit, input logic [15:0] start,
			input logic [15:0] step);
		logic [31:0] words [4];
		int n;
		words[lsbc_pkg::CFG_DIST_LIMIT] = limit;
		words[lsbc_pkg::CFG_START_ANGLE] = {16'($urandom), start};
		words[lsbc_pkg::CFG_ANGLE_STEP] = {16'($urandom), step};
		words[CFG_UNUSED] = $urandom;
		// The unused index goes last so that an alias onto a real register shows up.
		for (n = 0; n < 4; n++) begin
			cfg_we <= 1'b1;
			cfg_index <= 2'(n);
			cfg_data <= words[n];
			@(posedge clk);
			case (2'(n))
				lsbc_pkg::CFG_DIST_LIMIT:  mirror_limit = words[n];
				lsbc_pkg::CFG_START_ANGLE: mirror_start = words[n][15:0];
				lsbc_pkg::CFG_ANGLE_STEP:  mirror_step = words[n][15:0];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	function automatic void check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			m_axis_tready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (hold_served != hold_ticket) begin
			hold_served <= hold_ticket;
			hold_cnt <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !(sink_gaps_on && $urandom_range(0, 99) < 24);
		end
	end

	always @(posedge clk) begin : result_check
		lsbc_pkg::res_t want;
		lsbc_pkg::res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.x = m_axis_tdata[16:0];
			got.y = m_axis_tdata[33:17];
			got.label = m_axis_tdata[41:34];
			got.opens = m_axis_tuser[0];
			got.merge = m_axis_tuser[1];
			got.done = m_axis_tlast;
			if (pending_points.size() == 0) begin
				$error("result transfer with no point pending");
				mismatch_count++;
			end else begin
				want = pending_points.pop_front();
				check_field("point_x", want.x, got.x);
				check_field("point_y", want.y, got.y);
				check_field("cluster_label", want.label, got.label);
				check_field("opens_cluster", want.opens, got.opens);
				check_field("scan_done", want.done, got.done);
				check_field("wrap_merge", want.merge, got.merge);
				points_checked++;
				if (got.done)
					scans_seen++;
				if (got.merge)
					merges_seen++;
				if (got.label == 8'(LABEL_TOP))
					saturated_seen++;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int i;
		int k;
		int phase;
		int sent;
		int scan_len;
		int jit;
		int mode;
		logic [31:0] limit;
		logic [15:0] start;
		logic [15:0] step;
		logic [15:0] base;
		logic [15:0] rng;
		lsbc_pkg::res_t want;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIRECTED_ROWS; i++) begin
			want.x = directed_rows[i].x;
			want.y = directed_rows[i].y;
			want.label = '0;
			want.opens = 1'b1;
			want.done = directed_rows[i].last;
			want.merge = 1'b0;
			send_sample(directed_rows[i].rng, directed_rows[i].last, directed_rows[i].typed, want);
		end
		wait_drained();

		// Alternate the origin and full range so that every sample breaks and the
		// label runs into its top value; ending on the origin closes onto cluster 0.
		apply_setting(lsbc_pkg::DIST_LIMIT_RST, lsbc_pkg::START_ANGLE_RST,
			lsbc_pkg::ANGLE_STEP_RST);
		for (i = 0; i < 301; i++)
			send_sample((i % 2 == 0) ? 16'd0 : 16'hFFFF, i == 300, 1'b0, want);
		wait_drained();

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_drained();
			if (phase == 0) begin
				limit = '0;
				start = 16'hFFFF;
				step = 16'hFFFF;
			end else if (phase == 1) begin
				limit = '1;
				start = '0;
				step = '0;
			end else begin
				case ($urandom_range(0, 5))
					0: limit = '0;
					1: limit = '1;
					2: limit = lsbc_pkg::DIST_LIMIT_RST;
					3: limit = $urandom;
					4: limit = $urandom_range(0, 65535);
					default: limit = 32'd1 << $urandom_range(0, 31);
				endcase
				case ($urandom_range(0, 2))
					0: start = '0;
					1: start = 16'hFFFF;
					default: start = 16'($urandom);
				endcase
				case ($urandom_range(0, 5))
					0: step = '0;
					1: step = 16'hFFFF;
					2: step = lsbc_pkg::ANGLE_STEP_RST;
					3: step = 16'd1024;
					4: step = 16'($urandom_range(0, 512));
					default: step = 16'($urandom);
				endcase
			end
			apply_setting(limit, start, step);
			src_gaps_on = (phase != 4);
			sink_gaps_on = (phase != 4);
			sent = 0;
			while (sent < PHASE_SAMPLES) begin
				mode = $urandom_range(0, 9);
				if (mode == 0) begin
					send_sample(16'($urandom), $urandom_range(0, 7) == 0, 1'b0, want);
					sent++;
					if (phase == 6 && hold_ticket == 0 && sent >= 5)
						hold_ticket++;
				end else begin
					if ($urandom_range(0, 9) == 0)
						scan_len = 1;
					else if (mode == 1)
						scan_len = 64;
					else
						scan_len = $urandom_range(2, 40);
					base = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2047));
					case ($urandom_range(0, 3))
						0: jit = 0;
						1: jit = 4;
						2: jit = 64;
						default: jit = 1024;
					endcase
					for (k = 0; k < scan_len; k++) begin
						if ($urandom_range(0, 9) == 0)
							rng = 16'($urandom);
						else
							rng = base + 16'($urandom_range(0, 2 * jit)) - 16'(jit);
						send_sample(rng, k == scan_len - 1, 1'b0, want);
						sent++;
						if (phase == 6 && hold_ticket == 0 && sent >= 5)
							hold_ticket++;
					end
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d samples, checked %0d points over %0d finished scans.",
			samples_sent, points_checked, scans_seen);
		$display("Saw %0d wrap merges and %0d points at the top label, with a long output stall.",
			merges_seen, saturated_seen);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
